/* hw/rtl/sbce_pkg.sv */
`default_nettype none

package sbce_pkg;

   // Switches per bank; any value from 8 to 32 is supported.
   localparam int BANK_WIDTH = 32;

   // Fixed widths of the report and event fields.
   localparam int CODE_WIDTH   = 8;
   localparam int REPORT_WIDTH = 32;
   localparam int NUM_WIDTH    = 7;

   // Report codes.
   localparam logic [CODE_WIDTH-1:0] CODE_LOW_BANK  = 8'h19;
   localparam logic [CODE_WIDTH-1:0] CODE_HIGH_BANK = 8'h1A;

   // First switch number of each bank (switch numbers are one-based).
   localparam logic [NUM_WIDTH-1:0] BASE_LOW  = NUM_WIDTH'(1);
   localparam logic [NUM_WIDTH-1:0] BASE_HIGH = NUM_WIDTH'(BANK_WIDTH + 1);

   // Job queue between the report front end and the event sequencer.
   // The depth must be a power of two so the pointers wrap by themselves.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_WIDTH  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

   typedef logic [BANK_WIDTH-1:0] bank_bits_type;

   // One classified report: which switches get an event and their new states.
   typedef struct packed {
      logic          high_bank;
      bank_bits_type select;
      bank_bits_type bits;
   } job_type;

endpackage

`default_nettype wire

/* hw/rtl/switch_bank_change_event_generator.sv */
// Switch bank change event generator.
// Request channel (req_valid / req_stall): one switch report per beat, a report
// code and a switch bitmap. Code 0x19 addresses the low bank (switches 1 to
// BANK_WIDTH), code 0x1A the high bank; other codes are taken and dropped.
// Response channel (rsp_valid / rsp_stall): one event per beat, a one-based
// switch number and its state, in ascending order; rsp_last_event marks the
// final event of a report. A bank's first report gives an event per switch,
// later reports only for switches that changed.
// With the pipeline empty, a taken report is written to the job queue, loaded
// into the event sequencer, and its first event is registered in the output
// register; the sequencer steps past each unselected switch below it first.
// A job holds the event sequencer for a load step plus one step per switch
// position up to its highest event; reports without events make no job.
// A two-entry job queue lets the front end take reports while the sequencer
// works. A stalled response holds its beat; the sequencer then waits, the
// queue fills, and req_stall rises once the queue is full.
// Reset clears both stored bitmaps and the "seen" flags and empties the
// queue and the output register.
`default_nettype none

module switch_bank_change_event_generator
   import sbce_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic [CODE_WIDTH-1:0]   req_report_code,
   input  wire logic [REPORT_WIDTH-1:0] req_switch_bits,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic [NUM_WIDTH-1:0]         rsp_switch_number,
   output logic                         rsp_switch_on,
   output logic                         rsp_last_event
);

   logic    push;
   job_type push_job;
   logic    queue_full;
   logic    pop;
   job_type pop_job;
   logic    queue_empty;

   sbce_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_report_code (req_report_code),
      .req_switch_bits (req_switch_bits),
      .push            (push),
      .push_job        (push_job),
      .queue_full      (queue_full)
   );

   sbce_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (queue_full),
      .pop      (pop),
      .pop_job  (pop_job),
      .empty    (queue_empty)
   );

   sbce_back u_back (
      .clock             (clock),
      .reset             (reset),
      .pop               (pop),
      .pop_job           (pop_job),
      .queue_empty       (queue_empty),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_switch_number (rsp_switch_number),
      .rsp_switch_on     (rsp_switch_on),
      .rsp_last_event    (rsp_last_event)
   );

endmodule

`default_nettype wire

/* hw/rtl/sbce_queue.sv */
`default_nettype none

module sbce_queue
   import sbce_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type push_job,
   output logic         full,
   input  wire logic    pop,
   output job_type      pop_job,
   output logic         empty
);

   job_type                entry_ff [QUEUE_DEPTH];
   logic [QPTR_WIDTH-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_WIDTH-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_WIDTH-1:0]  count_ff, count_in;

   always_comb begin
      full    = (count_ff == QCNT_WIDTH'(QUEUE_DEPTH));
      empty   = (count_ff == '0);
      pop_job = entry_ff[rd_ptr_ff];

      wr_ptr_in = push ? wr_ptr_ff + QPTR_WIDTH'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_WIDTH'(1) : rd_ptr_ff;
      unique case ({push, pop})
         2'b10:   count_in = count_ff + QCNT_WIDTH'(1);
         2'b01:   count_in = count_ff - QCNT_WIDTH'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset) !(push && full))
      else $error("queue pushed while full");
   assert property (@(posedge clock) disable iff (reset) !(pop && empty))
      else $error("queue popped while empty");
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_WIDTH'(QUEUE_DEPTH))
      else $error("queue count out of range");
   assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + QCNT_WIDTH'(1)))
      else $error("queue count did not follow a push");
`endif

endmodule

`default_nettype wire

/* hw/rtl/sbce_front.sv */
`default_nettype none

module sbce_front
   import sbce_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic [CODE_WIDTH-1:0]   req_report_code,
   input  wire logic [REPORT_WIDTH-1:0] req_switch_bits,
   output logic                         push,
   output job_type                      push_job,
   input  wire logic                    queue_full
);

   bank_bits_type low_prev_ff, low_prev_in;
   bank_bits_type high_prev_ff, high_prev_in;
   logic          low_seen_ff, low_seen_in;
   logic          high_seen_ff, high_seen_in;

   logic          accept;
   logic          is_low;
   logic          is_high;
   bank_bits_type bits;
   bank_bits_type prev;
   logic          seen;

   always_comb begin
      req_stall = queue_full;
      accept    = req_valid && !queue_full;
      is_low    = (req_report_code == CODE_LOW_BANK);
      is_high   = (req_report_code == CODE_HIGH_BANK);
      bits      = req_switch_bits[BANK_WIDTH-1:0];
      prev      = is_high ? high_prev_ff : low_prev_ff;
      seen      = is_high ? high_seen_ff : low_seen_ff;

      // A bank's first report announces every switch of that bank.
      push_job.high_bank = is_high;
      push_job.bits      = bits;
      push_job.select    = seen ? (bits ^ prev) : '1;

      // Reports with no changed switches cause no events and need no job.
      push = accept && (is_low || is_high) && (push_job.select != '0);

      low_prev_in  = (accept && is_low) ? bits : low_prev_ff;
      low_seen_in  = low_seen_ff || (accept && is_low);
      high_prev_in = (accept && is_high) ? bits : high_prev_ff;
      high_seen_in = high_seen_ff || (accept && is_high);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_prev_ff  <= '0;
         high_prev_ff <= '0;
         low_seen_ff  <= 1'b0;
         high_seen_ff <= 1'b0;
      end else begin
         low_prev_ff  <= low_prev_in;
         high_prev_ff <= high_prev_in;
         low_seen_ff  <= low_seen_in;
         high_seen_ff <= high_seen_in;
      end
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      (accept && is_low) |=> low_seen_ff)
      else $error("low bank not marked seen after a report");
   assert property (@(posedge clock) disable iff (reset)
      (accept && is_high) |=> high_seen_ff)
      else $error("high bank not marked seen after a report");
   assert property (@(posedge clock) disable iff (reset)
      (accept && !is_low && !is_high) |=> ($stable(low_prev_ff) && $stable(high_prev_ff)))
      else $error("ignored report changed a stored bitmap");
`endif

endmodule

`default_nettype wire

/* hw/rtl/sbce_back.sv */
`default_nettype none

module sbce_back
   import sbce_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   output logic                      pop,
   input  wire job_type              pop_job,
   input  wire logic                 queue_empty,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [NUM_WIDTH-1:0]      rsp_switch_number,
   output logic                      rsp_switch_on,
   output logic                      rsp_last_event
);

   // The select and state bitmaps shift right by one switch per step, so
   // bit zero is always the switch whose number sits in num_ff.
   bank_bits_type          select_ff, select_in;
   bank_bits_type          bits_ff, bits_in;
   logic [NUM_WIDTH-1:0]   num_ff, num_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [NUM_WIDTH-1:0]   rsp_number_ff, rsp_number_in;
   logic                   rsp_on_ff, rsp_on_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic                   busy;
   logic                   out_free;
   logic                   emit;
   logic                   advance;

   always_comb begin
      busy     = (select_ff != '0);
      out_free = !rsp_valid_ff || !rsp_stall;
      emit     = busy && select_ff[0] && out_free;
      advance  = busy && (!select_ff[0] || out_free);
      pop      = !busy && !queue_empty;

      select_in = select_ff;
      bits_in   = bits_ff;
      num_in    = num_ff;
      if (pop) begin
         select_in = pop_job.select;
         bits_in   = pop_job.bits;
         num_in    = pop_job.high_bank ? BASE_HIGH : BASE_LOW;
      end else if (advance) begin
         select_in = select_ff >> 1;
         bits_in   = bits_ff >> 1;
         num_in    = num_ff + NUM_WIDTH'(1);
      end

      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_number_in = rsp_number_ff;
      rsp_on_in     = rsp_on_ff;
      rsp_last_in   = rsp_last_ff;
      if (emit) begin
         rsp_valid_in  = 1'b1;
         rsp_number_in = num_ff;
         rsp_on_in     = bits_ff[0];
         rsp_last_in   = ((select_ff >> 1) == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         select_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         select_ff    <= select_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bits_ff       <= bits_in;
      num_ff        <= num_in;
      rsp_number_ff <= rsp_number_in;
      rsp_on_ff     <= rsp_on_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_switch_number = rsp_number_ff;
   assign rsp_switch_on     = rsp_on_ff;
   assign rsp_last_event    = rsp_last_ff;

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      (emit && (select_ff >> 1) == '0) |=> !busy)
      else $error("job still busy after its last event");
   assert property (@(posedge clock) disable iff (reset)
      !(pop && busy))
      else $error("new job taken while a job is in progress");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_number_ff != '0))
      else $error("event carries switch number zero");
`endif

endmodule

`default_nettype wire
